/* rtl/smeu_pkg.sv */
// ----------------------------------------------------------------------------
// smeu_pkg: shared types and constants of the stack machine execute unit
// Opcodes, sequencer states, channel payloads and the control bundle to the
// arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package smeu_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned OP_W   = 5;
    localparam int unsigned VIDX_W = 4;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 5'd0,
        OP_LOAD  = 5'd1,
        OP_STORE = 5'd2,
        OP_ADD   = 5'd3,
        OP_SUB   = 5'd4,
        OP_MUL   = 5'd5,
        OP_DIV   = 5'd6,
        OP_GT    = 5'd7,
        OP_LT    = 5'd8,
        OP_GE    = 5'd9,
        OP_LE    = 5'd10,
        OP_EQ    = 5'd11,
        OP_NE    = 5'd12,
        OP_PRINT = 5'd13,
        OP_JZ    = 5'd14,
        OP_JMP   = 5'd15,
        OP_HALT  = 5'd16
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POPB,
        ST_POPA,
        ST_EXEC,
        ST_ALU,
        ST_DONE
    } state_t;

    // arithmetic unit sequencer
    typedef enum logic [1:0] { A_IDLE, A_MUL, A_DIV, A_FIN } astate_t;

    typedef struct packed {
        logic            start;
        logic [OP_W-1:0] op;
    } alu_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic dz;
    } alu_sts_t;

    // request channel payload
    typedef struct packed {
        logic [OP_W-1:0]   req_type;
        logic [DATA_W-1:0] immediate;
        logic [VIDX_W-1:0] var_index;
    } instr_t;

    // result channel payload
    typedef struct packed {
        logic              print_valid;
        logic [DATA_W-1:0] print_value;
        logic              branch_taken;
        logic              halted;
        logic              div_by_zero;
        logic              stack_overflow;
    } outcome_t;

endpackage

`default_nettype wire

/* rtl/smeu_if.sv */
// ----------------------------------------------------------------------------
// smeu_if: valid/ready channel
// Carries one beat of a payload of type PAYLOAD_T from source to sink.
// ----------------------------------------------------------------------------
`default_nettype none

interface smeu_if #(
    parameter type PAYLOAD_T = logic
);
    logic     valid;
    logic     ready;
    PAYLOAD_T data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/stack_machine_execute_unit_core.sv */
// ----------------------------------------------------------------------------
// stack_machine_execute_unit_core: integer stack-machine execute unit
// Runs one instruction per input beat against an operand stack and a
// variable file, and returns one result beat per instruction.
// ----------------------------------------------------------------------------
// Usage:
//   req  (sink):  one instruction per beat: req_type, immediate, var_index.
//   rsp  (source): exactly one result beat per instruction, in order.
//   req.ready is high only while the sequencer is idle and no result waits;
//   one instruction is in flight at a time.
// Sequence: a stack pop uses the single registered memory read port.
//   push, load, jmp, halt, unused codes: execute, then the result register.
//   store, print, jz: pop a, execute.  add, sub, compares: pop b, pop a, unit, execute.
//   mul: as add, with four 16x64 partial-product steps on the shared unit.
//   div: as add, with one quotient bit per cycle on the shared unit; a zero
//   divisor skips the quotient steps.
// Flow: one instruction at a time, the next only after the result is handed
// off; the divide dominates the worst case.
// Reset: stack empty, variable file reads zero (valid bit per entry), halt
// flag clear. The operand stack holds no reset value.
// Stall: a result holds in the output register until rsp.ready; no new
// instruction is taken meanwhile. After halt every beat returns halted only.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_machine_execute_unit_core
    import smeu_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 16,
    parameter int unsigned VAR_COUNT   = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    smeu_if.sink      req,
    smeu_if.source    rsp
);
    localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1);
    localparam int unsigned SA_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned VA_W = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

    state_t             state_reg, state_next;
    logic [SP_W-1:0]    sp_reg, sp_next;
    logic               halt_reg, halt_next;
    logic [OP_W-1:0]    op_reg;
    logic [DATA_W-1:0]  imm_reg;
    logic [VIDX_W-1:0]  vidx_reg;
    logic [DATA_W-1:0]  opa_reg, opb_reg;

    // result register
    logic               rv_reg, rv_next;
    logic               pvalid_reg, pvalid_next;
    logic [DATA_W-1:0]  pvalue_reg, pvalue_next;
    logic               br_reg, br_next;
    logic               dz_reg, dz_next;
    logic               ovf_reg, ovf_next;

    logic [DATA_W-1:0]  stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0]  var_mem   [VAR_COUNT];
    logic [VAR_COUNT-1:0] var_valid_reg;

    logic               st_we;
    logic [SA_W-1:0]    st_waddr;
    logic [DATA_W-1:0]  st_wdata;
    logic [DATA_W-1:0]  st_rdata;
    logic [SA_W-1:0]    st_raddr;
    logic               pop_ok;

    logic               vr_ok;
    logic [DATA_W-1:0]  var_rdata;
    logic               var_we;

    alu_ctl_t           alu_ctl;
    alu_sts_t           alu_sts;
    logic [DATA_W-1:0]  alu_res;

    logic               accept;
    logic               vidx_in;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE) && !rv_reg;
    assign vidx_in  = ({{(32-VIDX_W){1'b0}}, vidx_reg} < VAR_COUNT);
    assign pop_ok   = (sp_reg != '0);
    // address the entry that will be on top after this edge
    assign st_raddr = SA_W'(sp_next - 1'b1);

    smeu_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (alu_ctl),
        .a      (opa_reg),
        .b      (opb_reg),
        .sts    (alu_sts),
        .result (alu_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (halt_reg)
                        state_next = ST_DONE;
                    else if (req.data.req_type == OP_STORE
                             || req.data.req_type == OP_PRINT
                             || req.data.req_type == OP_JZ)
                        state_next = ST_POPA;
                    else if (req.data.req_type >= OP_ADD && req.data.req_type <= OP_NE)
                        state_next = ST_POPB;
                    else
                        state_next = ST_EXEC;
                end
            end
            ST_POPB: state_next = ST_POPA;
            ST_POPA:
            begin
                if (op_reg >= OP_ADD && op_reg <= OP_NE)
                    state_next = ST_ALU;
                else
                    state_next = ST_EXEC;
            end
            ST_ALU:
            begin
                if (alu_sts.done)
                    state_next = ST_EXEC;
            end
            ST_EXEC: state_next = ST_IDLE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath outputs
    always_comb
    begin
        sp_next     = sp_reg;
        halt_next   = halt_reg;
        rv_next     = rv_reg;
        pvalid_next = pvalid_reg;
        pvalue_next = pvalue_reg;
        br_next     = br_reg;
        dz_next     = dz_reg;
        ovf_next    = ovf_reg;
        st_we       = 1'b0;
        st_waddr    = SA_W'(sp_reg);
        st_wdata    = imm_reg;
        var_we      = 1'b0;
        alu_ctl.start = 1'b0;
        alu_ctl.op    = op_reg;

        if (rsp.valid && rsp.ready)
            rv_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // clear the result fields only when a new beat comes in
                if (accept)
                begin
                    pvalid_next = 1'b0;
                    pvalue_next = '0;
                    br_next     = 1'b0;
                    dz_next     = 1'b0;
                    ovf_next    = 1'b0;
                end
            end
            ST_POPB:
            begin
                // top of stack becomes operand b
                if (pop_ok)
                    sp_next = sp_reg - 1'b1;
            end
            ST_POPA:
            begin
                if (pop_ok)
                    sp_next = sp_reg - 1'b1;
            end
            ST_ALU:
            begin
                // both operands are registered now; kick the unit once
                alu_ctl.start = !alu_sts.busy;
            end
            ST_EXEC:
            begin
                rv_next = 1'b1;
                priority case (1'b1)
                    (op_reg == OP_PUSH || op_reg == OP_LOAD
                     || (op_reg >= OP_ADD && op_reg <= OP_NE)):
                    begin
                        if (op_reg == OP_LOAD)
                            st_wdata = vr_ok ? var_rdata : '0;
                        else if (op_reg != OP_PUSH)
                            st_wdata = alu_res;
                        dz_next = (op_reg == OP_DIV) && alu_sts.dz;
                        if ({{(32-SP_W){1'b0}}, sp_reg} >= STACK_DEPTH)
                            ovf_next = 1'b1;
                        else
                        begin
                            st_we   = 1'b1;
                            sp_next = sp_reg + 1'b1;
                        end
                    end
                    (op_reg == OP_STORE): var_we = vidx_in;
                    (op_reg == OP_PRINT):
                    begin
                        pvalid_next = 1'b1;
                        pvalue_next = opa_reg;
                    end
                    (op_reg == OP_JZ):  br_next = (opa_reg == '0);
                    (op_reg == OP_JMP): br_next = 1'b1;
                    (op_reg == OP_HALT): halt_next = 1'b1;
                    default: ;
                endcase
            end
            ST_DONE: rv_next = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sp_reg        <= '0;
            halt_reg      <= 1'b0;
            rv_reg        <= 1'b0;
            var_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            halt_reg  <= halt_next;
            rv_reg    <= rv_next;
            if (var_we)
                var_valid_reg[VA_W'(vidx_reg)] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        pvalid_reg <= pvalid_next;
        pvalue_reg <= pvalue_next;
        br_reg     <= br_next;
        dz_reg     <= dz_next;
        ovf_reg    <= ovf_next;
        if (accept)
        begin
            op_reg   <= req.data.req_type;
            imm_reg  <= req.data.immediate;
            vidx_reg <= req.data.var_index;
        end
        // popped operands: b first, then a; empty pop reads zero
        if (state_reg == ST_POPB)
            opb_reg <= pop_ok ? st_rdata : '0;
        if (state_reg == ST_POPA)
            opa_reg <= pop_ok ? st_rdata : '0;
    end

    // operand stack: one write, one registered read of the next top entry
    always_ff @(posedge clk)
    begin
        if (st_we)
            stack_mem[st_waddr] <= st_wdata;
        st_rdata <= stack_mem[st_raddr];
    end

    // variable file: read registered at accept, write at store
    always_ff @(posedge clk)
    begin
        if (var_we)
            var_mem[VA_W'(vidx_reg)] <= opa_reg;
        if (accept)
            var_rdata <= var_mem[VA_W'(req.data.var_index)];
        if (accept)
            vr_ok <= ({{(32-VIDX_W){1'b0}}, req.data.var_index} < VAR_COUNT)
                     && var_valid_reg[VA_W'(req.data.var_index)];
    end

    assign rsp.valid               = rv_reg;
    assign rsp.data.print_valid    = pvalid_reg;
    assign rsp.data.print_value    = pvalue_reg;
    assign rsp.data.branch_taken   = br_reg;
    assign rsp.data.halted         = halt_reg;
    assign rsp.data.div_by_zero    = dz_reg;
    assign rsp.data.stack_overflow = ovf_reg;

endmodule

`default_nettype wire

/* rtl/smeu_alu.sv */
// ----------------------------------------------------------------------------
// smeu_alu: shared multi-cycle arithmetic unit
// Add, subtract, compare in one step; multiply as 16x64 partial products over
// four steps; signed divide as one restoring quotient bit per step.
// ----------------------------------------------------------------------------
`default_nettype none

module smeu_alu
    import smeu_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire smeu_pkg::alu_ctl_t       ctl,
    input  wire logic [smeu_pkg::DATA_W-1:0] a,
    input  wire logic [smeu_pkg::DATA_W-1:0] b,
    output smeu_pkg::alu_sts_t            sts,
    output logic [smeu_pkg::DATA_W-1:0]   result
);
    astate_t             st_reg, st_next;
    logic [6:0]          cnt_reg, cnt_next;
    logic [DATA_W-1:0]   acc_reg, acc_next;
    logic [DATA_W-1:0]   rem_reg, rem_next;
    logic [DATA_W-1:0]   quo_reg, quo_next;
    logic [DATA_W-1:0]   mb_reg, mb_next;
    logic [DATA_W-1:0]   ma_reg, ma_next;
    logic                neg_reg, neg_next;
    logic                dz_reg, dz_next;
    logic [DATA_W-1:0]   res_reg, res_next;

    logic                slt_ab, slt_ba;
    logic [DATA_W-1:0]   abs_a, abs_b;
    logic [DATA_W:0]     rem_sh, rem_sub;
    logic [15:0]         mpart;
    logic [DATA_W+15:0]  pprod;

    assign slt_ab = $signed(a) < $signed(b);
    assign slt_ba = $signed(b) < $signed(a);
    assign abs_a  = a[DATA_W-1] ? (~a + 1'b1) : a;
    assign abs_b  = b[DATA_W-1] ? (~b + 1'b1) : b;
    assign rem_sh  = {rem_reg, ma_reg[DATA_W-1]};
    assign rem_sub = rem_sh - {1'b0, mb_reg};
    assign mpart   = mb_reg[15:0];
    assign pprod   = {16'd0, ma_reg} * {{DATA_W{1'b0}}, mpart};

    always_comb
    begin
        st_next  = st_reg;
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        mb_next  = mb_reg;
        ma_next  = ma_reg;
        neg_next = neg_reg;
        dz_next  = dz_reg;
        res_next = res_reg;
        unique case (st_reg)
            A_IDLE:
            begin
                if (ctl.start)
                begin
                    dz_next  = 1'b0;
                    cnt_next = '0;
                    unique case (ctl.op)
                        OP_ADD:  begin res_next = a + b; st_next = A_FIN; end
                        OP_SUB:  begin res_next = a - b; st_next = A_FIN; end
                        OP_GT:   begin res_next = {63'd0, slt_ba};  st_next = A_FIN; end
                        OP_LT:   begin res_next = {63'd0, slt_ab};  st_next = A_FIN; end
                        OP_GE:   begin res_next = {63'd0, !slt_ab}; st_next = A_FIN; end
                        OP_LE:   begin res_next = {63'd0, !slt_ba}; st_next = A_FIN; end
                        OP_EQ:   begin res_next = {63'd0, a == b};  st_next = A_FIN; end
                        OP_NE:   begin res_next = {63'd0, a != b};  st_next = A_FIN; end
                        OP_MUL:
                        begin
                            ma_next  = a;
                            mb_next  = b;
                            acc_next = '0;
                            st_next  = A_MUL;
                        end
                        OP_DIV:
                        begin
                            if (b == '0)
                            begin
                                dz_next  = 1'b1;
                                res_next = '0;
                                st_next  = A_FIN;
                            end
                            else
                            begin
                                ma_next  = abs_a;
                                mb_next  = abs_b;
                                neg_next = a[DATA_W-1] ^ b[DATA_W-1];
                                rem_next = '0;
                                quo_next = '0;
                                st_next  = A_DIV;
                            end
                        end
                        default: begin res_next = '0; st_next = A_FIN; end
                    endcase
                end
            end
            A_MUL:
            begin
                // add one 16-bit slice product, then shift the b operand
                acc_next = acc_reg + (pprod[DATA_W-1:0] << {cnt_reg[1:0], 4'd0});
                mb_next  = mb_reg >> 16;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    res_next = acc_reg + (pprod[DATA_W-1:0] << 48);
                    st_next  = A_FIN;
                end
            end
            A_DIV:
            begin
                ma_next = ma_reg << 1;
                if (!rem_sub[DATA_W])
                begin
                    rem_next = rem_sub[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    res_next = neg_reg ? (~quo_next + 1'b1) : quo_next;
                    st_next  = A_FIN;
                end
            end
            A_FIN:   st_next = A_IDLE;
            default: st_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= A_IDLE;
            cnt_reg <= '0;
            dz_reg  <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            dz_reg  <= dz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        mb_reg  <= mb_next;
        ma_reg  <= ma_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        sts.busy = (st_reg != A_IDLE);
        sts.done = (st_reg == A_FIN);
        sts.dz   = dz_reg;
    end
    assign result = res_reg;

endmodule

`default_nettype wire

/* rtl/smeu_checker.sv */
// ----------------------------------------------------------------------------
// smeu_checker: port-level checks of the execute unit
// Watches the request and result channels over time.
// ----------------------------------------------------------------------------
`default_nettype none

module smeu_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire logic halted,
    input wire logic print_valid,
    input wire logic branch_taken
);
    // a result beat stays offered until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result beat dropped under stall");

    // no new instruction while a result waits
    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request taken while result pending");

    // one beat in flight: after accept, not ready next cycle
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request accepted in flight");

    // halt is sticky on the result channel
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && halted |=> halted)
        else $error("halted flag cleared");

    // print and branch never come together
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(print_valid && branch_taken))
        else $error("print and branch in one result");
endmodule

bind stack_machine_execute_unit_core smeu_checker u_smeu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .halted       (rsp.data.halted),
    .print_valid  (rsp.data.print_valid),
    .branch_taken (rsp.data.branch_taken)
);

`default_nettype wire
